// ----- src/wsalu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wsalu_pkg;

    // Internal operand width; ports stay at two 64-bit halves
    localparam int DATA_WIDTH = 128;
    localparam int PORT_WIDTH = 128;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    // Command codes
    localparam logic [3:0] CMD_ADD = 4'd0;
    localparam logic [3:0] CMD_SUB = 4'd1;
    localparam logic [3:0] CMD_AND = 4'd2;
    localparam logic [3:0] CMD_OR  = 4'd3;
    localparam logic [3:0] CMD_XOR = 4'd4;
    localparam logic [3:0] CMD_NOT = 4'd5;
    localparam logic [3:0] CMD_SHL = 4'd6;
    localparam logic [3:0] CMD_SAR = 4'd7;
    localparam logic [3:0] CMD_ROL = 4'd8;
    localparam logic [3:0] CMD_ROR = 4'd9;
    localparam logic [3:0] CMD_MUL = 4'd10;
    localparam logic [3:0] CMD_DIV = 4'd11;

    typedef struct packed {
        logic [3:0]  command;
        logic [63:0] a_high;
        logic [63:0] a_low;
        logic [63:0] b_high;
        logic [63:0] b_low;
        logic [6:0]  shift_amount;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic        divide_by_zero;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DIVFIX,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic mul_step;
        logic div_step;
        logic div_fix;
        logic publish;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic b_zero;
        logic last;
    } ctrl_status_t;

    // Fit a 128-bit port operand to the internal width (truncate or sign-extend)
    function automatic logic [DATA_WIDTH-1:0] fit_operand(input logic [63:0] hi,
                                                          input logic [63:0] lo);
        logic [PORT_WIDTH-1:0] x;
        logic [DATA_WIDTH-1:0] r;
        x = {hi, lo};
        for (int i = 0; i < DATA_WIDTH; i++) begin
            r[i] = (i < PORT_WIDTH) ? x[i] : x[PORT_WIDTH-1];
        end
        return r;
    endfunction

    // Sign-extend an internal result out to the 128-bit port
    function automatic logic [PORT_WIDTH-1:0] widen_result(input logic [DATA_WIDTH-1:0] v);
        logic [PORT_WIDTH-1:0] r;
        for (int i = 0; i < PORT_WIDTH; i++) begin
            r[i] = (i < DATA_WIDTH) ? v[i] : v[DATA_WIDTH-1];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/wide_signed_integer_alu_top.sv -----
// Wide signed integer ALU, 128-bit two's complement.
// Input channel s_valid/s_ready/s_data carries one request: a command, operands
// a and b as 64-bit halves, and a shift amount. Output channel m_valid/m_ready/
// m_data returns one result per request: the 128-bit result and a
// divide-by-zero flag.
// Add, sub, logic, shift and rotate requests and a divide by zero finish
// after the execute state; multiply runs one shift-add step per operand
// bit, and divide one restoring step per bit plus a sign-fix step.
// One request is processed at a time; s_ready is high only while the block is
// idle, so a new request is taken only once the previous result has moved
// into the output register.
// A finished result sits in the output register while the next request is
// accepted and processed; if the receiver stalls, the block holds its result
// until the output register is free.
// Reset (aresetn low, synchronous) returns the controller to idle and drops
// m_valid; no request in flight survives it.
`timescale 1ns / 1ps
`default_nettype none

module wide_signed_integer_alu_top (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire wsalu_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output wsalu_pkg::out_item_t      m_data
);
    import wsalu_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    wsalu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wsalu_dp u_dp (
        .aclk   (aclk),
        .s_data (s_data),
        .cmd    (cmd),
        .status (status),
        .m_data (m_data)
    );

endmodule

`default_nettype wire

// ----- src/wsalu_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wsalu_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    input  wire wsalu_pkg::ctrl_status_t status,
    output wsalu_pkg::ctrl_cmd_t         cmd
);
    import wsalu_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (status.is_mul) begin
                    state_next = ST_MUL;
                end else if (status.is_div && !status.b_zero) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL: begin
                if (status.last) state_next = ST_DONE;
            end
            ST_DIV: begin
                if (status.last) state_next = ST_DIVFIX;
            end
            ST_DIVFIX: state_next = ST_DONE;
            ST_DONE: begin
                if (slot_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_EXEC:   cmd.exec     = 1'b1;
            ST_MUL:    cmd.mul_step = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_DIVFIX: cmd.div_fix  = 1'b1;
            ST_DONE:   cmd.publish  = slot_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

    // Hold the result valid until the receiver takes it
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- src/wsalu_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wsalu_dp (
    input  wire logic                    aclk,
    input  wire wsalu_pkg::in_item_t     s_data,
    input  wire wsalu_pkg::ctrl_cmd_t    cmd,
    output wsalu_pkg::ctrl_status_t      status,
    output wsalu_pkg::out_item_t         m_data
);
    import wsalu_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [W-1:0]     a_reg, a_next;
    logic [W-1:0]     b_reg, b_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     res_reg, res_next;
    logic             dz_reg, dz_next;
    logic             sdiff_reg, sdiff_next;
    logic [3:0]       op_reg;
    logic [6:0]       sh_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    out_item_t        out_reg;

    logic [W-1:0]     alu_res;
    logic [W-1:0]     rem_shift;
    logic [W:0]       diff;
    logic             ge;
    logic             sa, sb;

    assign sa = a_reg[W-1];
    assign sb = b_reg[W-1];

    // Decode the non-iterative commands
    always_comb begin
        unique case (op_reg)
            CMD_ADD: alu_res = a_reg + b_reg;
            CMD_SUB: alu_res = a_reg - b_reg;
            CMD_AND: alu_res = a_reg & b_reg;
            CMD_OR:  alu_res = a_reg | b_reg;
            CMD_XOR: alu_res = a_reg ^ b_reg;
            CMD_NOT: alu_res = ~a_reg;
            CMD_SHL: alu_res = a_reg << sh_reg;
            CMD_SAR: alu_res = W'($signed(a_reg) >>> sh_reg);
            CMD_ROL: alu_res = {a_reg[W-2:0], a_reg[W-1]};
            CMD_ROR: alu_res = {a_reg[0], a_reg[W-1:1]};
            default: alu_res = '0;
        endcase
    end

    // One restoring-division step: shift in a numerator bit, trial subtract
    assign rem_shift = {rem_reg[W-2:0], a_reg[W-1]};
    assign diff      = {1'b0, rem_shift} - {1'b0, b_reg};
    assign ge        = !diff[W];

    // Advance the operand, accumulator and quotient registers
    always_comb begin
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        dz_next    = dz_reg;
        sdiff_next = sdiff_reg;
        count_next = count_reg;
        if (cmd.load) begin
            a_next = fit_operand(s_data.a_high, s_data.a_low);
            b_next = fit_operand(s_data.b_high, s_data.b_low);
        end
        if (cmd.exec) begin
            res_next   = alu_res;
            dz_next    = 1'b0;
            acc_next   = '0;
            rem_next   = '0;
            count_next = '0;
            sdiff_next = sa ^ sb;
            if (status.is_div) begin
                res_next = '0;
                dz_next  = status.b_zero;
                a_next   = sa ? (~a_reg + W'(1)) : a_reg;
                b_next   = sb ? (~b_reg + W'(1)) : b_reg;
            end
        end
        if (cmd.mul_step) begin
            if (b_reg[0]) acc_next = acc_reg + a_reg;
            a_next     = {a_reg[W-2:0], 1'b0};
            b_next     = {1'b0, b_reg[W-1:1]};
            count_next = count_reg + CNT_W'(1);
            if (status.last) res_next = status.last && b_reg[0] ? acc_reg + a_reg : acc_reg;
        end
        if (cmd.div_step) begin
            rem_next   = ge ? diff[W-1:0] : rem_shift;
            a_next     = {a_reg[W-2:0], ge};
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.div_fix) begin
            res_next = sdiff_reg ? (~a_reg + W'(1)) : a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
        dz_reg    <= dz_next;
        sdiff_reg <= sdiff_next;
        count_reg <= count_next;
        if (cmd.load) begin
            op_reg <= s_data.command;
            sh_reg <= s_data.shift_amount;
        end
        // Drop the finished result into the output register
        if (cmd.publish) begin
            {out_reg.result_high, out_reg.result_low} <= widen_result(res_reg);
            out_reg.divide_by_zero                    <= dz_reg;
        end
    end

    assign status.is_mul = (op_reg == CMD_MUL);
    assign status.is_div = (op_reg == CMD_DIV);
    assign status.b_zero = (b_reg == '0);
    assign status.last   = (count_reg == CNT_W'(W - 1));
    assign m_data        = out_reg;

endmodule

`default_nettype wire

// ----- src/wsalu_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wsalu_checker (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire wsalu_pkg::out_item_t m_data
);
    import wsalu_pkg::*;

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A stalled result stays offered
    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped under stall");

    // A stalled result keeps its payload
    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("m_data changed under stall");

    // A zero divisor always returns a zero result
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.divide_by_zero |->
            (m_data.result_high == 64'd0) && (m_data.result_low == 64'd0))
        else $error("divide_by_zero with nonzero result");

    // No result can appear the cycle after a request is taken
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared too early");

endmodule

bind wide_signed_integer_alu_top wsalu_checker u_wsalu_checker (.*);

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import wsalu_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 1200;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 140;
    localparam int PHASE_ITEMS    = 280;
    localparam int PRESSURE_ITEMS = 16;
    localparam int PRINT_LIMIT    = 30;
    // Top of the 4-bit command field; codes above CMD_DIV are spare
    localparam int CMD_FIELD_MAX  = 15;

    localparam logic [127:0] ALL_ONES = {128{1'b1}};
    localparam logic [127:0] MIN_NEG  = {1'b1, 127'b0};
    localparam logic [127:0] MAX_POS  = {1'b0, {127{1'b1}}};
    localparam logic [127:0] PATTERN  = {64'hF0F0_1234_A5A5_8001, 64'h0FF0_CAFE_5A5A_7FFE};

    // Expected ALU results, held in request order
    class alu_scoreboard;
        out_item_t pending[$];
        int        errors;
        int        checked;
        int        mul_count;
        int        div_count;
        int        zero_div_count;

        // Compute one ALU result at the block's internal width
        function out_item_t alu_result(in_item_t req);
            logic [DATA_WIDTH-1:0] a;
            logic [DATA_WIDTH-1:0] b;
            logic [DATA_WIDTH-1:0] r;
            logic [DATA_WIDTH-1:0] mag_a;
            logic [DATA_WIDTH-1:0] mag_b;
            logic [DATA_WIDTH-1:0] quo;
            logic [127:0]          port_r;
            out_item_t             res;
            a = $signed({req.a_high, req.a_low});
            b = $signed({req.b_high, req.b_low});
            r = '0;
            res.divide_by_zero = 1'b0;
            case (req.command)
                CMD_ADD: r = a + b;
                CMD_SUB: r = a - b;
                CMD_AND: r = a & b;
                CMD_OR:  r = a | b;
                CMD_XOR: r = a ^ b;
                CMD_NOT: r = ~a;
                CMD_SHL: r = a << req.shift_amount;
                CMD_SAR: r = $signed(a) >>> req.shift_amount;
                CMD_ROL: r = {a[DATA_WIDTH-2:0], a[DATA_WIDTH-1]};
                CMD_ROR: r = {a[0], a[DATA_WIDTH-1:1]};
                CMD_MUL: r = a * b;
                CMD_DIV: begin
                    if (b == '0) begin
                        res.divide_by_zero = 1'b1;
                    end else begin
                        // Divide magnitudes, then restore the sign
                        mag_a = a[DATA_WIDTH-1] ? -a : a;
                        mag_b = b[DATA_WIDTH-1] ? -b : b;
                        quo   = mag_a / mag_b;
                        r     = (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -quo : quo;
                    end
                end
                default: r = '0;
            endcase
            port_r = $signed(r);
            res.result_high = port_r[127:64];
            res.result_low  = port_r[63:0];
            return res;
        endfunction

        function void note_request(in_item_t req);
            if (req.command == CMD_MUL) mul_count++;
            if (req.command == CMD_DIV) begin
                div_count++;
                if ({req.b_high, req.b_low} == '0) zero_div_count++;
            end
            pending = {pending, alu_result(req)};
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("result %h with no request pending", got));
            end else begin
                want = pending.pop_front();
                checked++;
                if (got.result_high !== want.result_high)
                    report_mismatch($sformatf("result %0d result_high got %h want %h",
                                              checked, got.result_high, want.result_high));
                if (got.result_low !== want.result_low)
                    report_mismatch($sformatf("result %0d result_low got %h want %h",
                                              checked, got.result_low, want.result_low));
                if (got.divide_by_zero !== want.divide_by_zero)
                    report_mismatch($sformatf("result %0d divide_by_zero got %b want %b",
                                              checked, got.divide_by_zero,
                                              want.divide_by_zero));
            end
        endtask
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    alu_scoreboard sb = new;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_output    = 1'b0;
    int quiet_cycles   = 0;
    int sent_count     = 0;

    wide_signed_integer_alu_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Track both handshakes and bail out if traffic stops
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_request(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Drive m_ready: random stalls, or one long hold when asked
    initial begin
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_output) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_output = 1'b0;
            end else begin
                m_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
                @(posedge aclk);
            end
        end
    end

    function automatic in_item_t make_req(logic [3:0] cmd, logic [127:0] a,
                                          logic [127:0] b, logic [6:0] sh);
        in_item_t req;
        req.command      = cmd;
        req.a_high       = a[127:64];
        req.a_low        = a[63:0];
        req.b_high       = b[127:64];
        req.b_low        = b[63:0];
        req.shift_amount = sh;
        return req;
    endfunction

    // Bias operands toward the edges of the signed range
    function automatic logic [127:0] pick_operand();
        logic [127:0] v;
        logic [63:0]  half;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = 128'd1;
            2: v = ALL_ONES;
            3: v = MIN_NEG;
            4: v = MAX_POS;
            5: v = 128'($urandom_range(0, 1000));
            6: begin
                v = 128'($urandom_range(1, 1000));
                v = -v;
            end
            7: begin
                half = {$urandom(), $urandom()};
                v    = $signed(half);
            end
            default: v = {$urandom(), $urandom(), $urandom(), $urandom()};
        endcase
        return v;
    endfunction

    // Divisors: some zero, many small so quotients stay interesting
    function automatic logic [127:0] pick_divisor();
        logic [127:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1, 2, 3: begin
                v = 128'($urandom_range(1, 300));
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = pick_operand();
        endcase
        return v;
    endfunction

    function automatic logic [6:0] pick_shift();
        logic [6:0] sh;
        case ($urandom_range(0, 9))
            0: sh = 7'd0;
            1: sh = 7'd127;
            2: sh = 7'd64;
            3: sh = 7'd63;
            default: sh = 7'($urandom_range(0, 127));
        endcase
        return sh;
    endfunction

    function automatic in_item_t random_request();
        logic [3:0]   cmd;
        logic [127:0] a;
        logic [127:0] b;
        if ($urandom_range(0, 19) == 0) begin
            cmd = 4'($urandom_range(CMD_DIV + 1, CMD_FIELD_MAX));
        end else begin
            cmd = 4'($urandom_range(CMD_ADD, CMD_DIV));
        end
        a = pick_operand();
        b = (cmd == CMD_DIV) ? pick_divisor() : pick_operand();
        return make_req(cmd, a, b, pick_shift());
    endfunction

    // Offer one request after a random idle gap; hold it until accepted
    task automatic send_request(input in_item_t req);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_request(random_request());
    endtask

    task automatic run_directed();
        int c;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Wrap-around add and subtract
        send_request(make_req(CMD_ADD, MAX_POS, 128'd1, 7'd0));
        send_request(make_req(CMD_ADD, ALL_ONES, ALL_ONES, 7'd127));
        send_request(make_req(CMD_SUB, MIN_NEG, 128'd1, 7'd0));
        send_request(make_req(CMD_SUB, '0, ALL_ONES, 7'd0));
        // Bitwise operations; not ignores b
        send_request(make_req(CMD_AND, PATTERN, ~PATTERN ^ MIN_NEG, 7'd0));
        send_request(make_req(CMD_OR,  PATTERN, MAX_POS, 7'd0));
        send_request(make_req(CMD_XOR, PATTERN, ALL_ONES, 7'd0));
        send_request(make_req(CMD_NOT, '0, ALL_ONES, 7'd3));
        // Shifts at the extremes of the amount
        send_request(make_req(CMD_SHL, 128'd1, PATTERN, 7'd127));
        send_request(make_req(CMD_SHL, ALL_ONES, '0, 7'd0));
        send_request(make_req(CMD_SAR, MIN_NEG, PATTERN, 7'd127));
        send_request(make_req(CMD_SAR, MAX_POS, '0, 7'd127));
        send_request(make_req(CMD_SAR, PATTERN, '0, 7'd64));
        // Rotates move one bit and ignore the shift amount
        send_request(make_req(CMD_ROL, MIN_NEG | 128'd1, PATTERN, 7'd5));
        send_request(make_req(CMD_ROR, 128'd1, PATTERN, 7'd100));
        // Multiply: overflow and sign combinations
        send_request(make_req(CMD_MUL, MIN_NEG, ALL_ONES, 7'd0));
        send_request(make_req(CMD_MUL, MAX_POS, MAX_POS, 7'd0));
        send_request(make_req(CMD_MUL, 128'(-3), 128'd7, 7'd0));
        // Divide: truncation toward zero, overflow, zero divisor
        send_request(make_req(CMD_DIV, 128'd7, 128'(-2), 7'd0));
        send_request(make_req(CMD_DIV, 128'(-7), 128'd2, 7'd0));
        send_request(make_req(CMD_DIV, MIN_NEG, ALL_ONES, 7'd0));
        send_request(make_req(CMD_DIV, PATTERN, '0, 7'd0));
        send_request(make_req(CMD_DIV, '0, 128'd5, 7'd0));
        // Spare command codes return zero
        for (c = CMD_DIV + 1; c <= CMD_FIELD_MAX; c++) begin
            send_request(make_req(4'(c), PATTERN, ALL_ONES, 7'd9));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_random(PHASE_ITEMS, 0, 0);
        run_random(PHASE_ITEMS, 79, 0);
        run_random(PHASE_ITEMS, 0, 79);

        // Hold the output off so the block backs up into its input
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_output    = 1'b1;
        repeat (PRESSURE_ITEMS) send_request(random_request());

        run_random(PHASE_ITEMS, 21, 21);
        s_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results for %0d requests: %0d multiplies, %0d divides (%0d by zero).",
                 sb.checked, sent_count, sb.mul_count, sb.div_count, sb.zero_div_count);
        $display("Traffic: free-running, idle sender, stalling receiver, mixed, long output hold.");
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
